### hw/rtl/fcd_pkg.sv
package fcd_pkg;

  // Widest pair index the store can need (MODULES up to 4096, two modules per row)
  localparam int unsigned PAIR_IDX_W = 11;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned ADDR_W     = 12;
  localparam logic [15:0] BASE_RESET = 16'd100;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [PAIR_IDX_W-1:0] pair;
    logic [WORD_W-1:0]     word;
  } fcd_entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOAD,
    B_EMIT
  } back_state_e;

endpackage

### hw/rtl/fcd_front.sv
module fcd_front #(
  parameter int unsigned PAIRS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        object_id_i,
  input  logic [15:0]        state_word_i,
  input  logic               q_full_i,
  input  logic               clearing_i,
  output logic               push_o,
  output fcd_pkg::fcd_entry_t entry_o
);

  logic [15:0] base_q, base_d;
  logic [16:0] diff;
  logic        in_range;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    base_d = base_q;
    if (cfg_valid_i) begin
      base_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= fcd_pkg::BASE_RESET;
    end else begin
      base_q <= base_d;
    end
  end

  // borrow bit set when the object lies below the base
  assign diff     = {1'b0, object_id_i} - {1'b0, base_q};
  assign in_range = !diff[16] && (diff[15:0] < 16'(PAIRS));

  assign in_ready_o    = !q_full_i && !clearing_i;
  assign push_o        = in_valid_i && in_ready_o && in_range;
  assign entry_o.pair  = diff[fcd_pkg::PAIR_IDX_W-1:0];
  assign entry_o.word  = state_word_i;

endmodule

### hw/rtl/fcd_queue.sv
module fcd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fcd_pkg::fcd_entry_t entry_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output fcd_pkg::fcd_entry_t head_o,
  output logic [1:0]          count_o
);

  fcd_pkg::fcd_entry_t slot_q [fcd_pkg::QUEUE_DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'(fcd_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == 2'd0);
  assign head_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### hw/rtl/fcd_back.sv
module fcd_back #(
  parameter int unsigned PAIRS = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  fcd_pkg::fcd_entry_t q_head_i,
  output logic                q_pop_o,
  output logic                clearing_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [11:0]         sensor_address_o,
  output logic                occupied_o,
  output logic                last_o
);

  localparam int unsigned PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  logic [15:0] lvl_mem_q [PAIRS];
  logic [15:0] rd_data_q;
  logic [PAIR_W-1:0] rd_addr;

  fcd_pkg::back_state_e state_q, state_d;
  logic [PAIR_W-1:0] pair_q, pair_d;
  logic [15:0]       word_q, word_d;
  logic [15:0]       mask_q, mask_d;
  logic              clr_q, clr_d;
  logic [PAIR_W-1:0] clr_addr_q, clr_addr_d;

  logic        out_valid_q, out_valid_d;
  logic [11:0] out_addr_q, out_addr_d;
  logic        out_occ_q, out_occ_d;
  logic        out_last_q, out_last_d;

  logic [3:0]  bit_idx;
  logic [11:0] addr_sum;
  logic        out_free;
  logic        mem_we;
  logic [PAIR_W-1:0] mem_wa;
  logic [15:0] mem_wd;

  assign rd_addr    = q_head_i.pair[PAIR_W-1:0];
  assign clearing_o = clr_q;
  assign out_free   = !out_valid_q || out_ready_i;

  // lowest changed pin still pending
  always_comb begin
    bit_idx = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (mask_q[i]) begin
        bit_idx = 4'(i);
      end
    end
  end

  // 16 * pair + pin + 1, kept to 12 bits
  assign addr_sum = 12'({pair_q, 4'b0000}) + {8'd0, bit_idx} + 12'd1;

  always_comb begin
    state_d     = state_q;
    pair_d      = pair_q;
    word_d      = word_q;
    mask_d      = mask_q;
    clr_d       = clr_q;
    clr_addr_d  = clr_addr_q;
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_occ_d   = out_occ_q;
    out_last_d  = out_last_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = pair_q;
    mem_wd      = word_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (clr_q) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_q;
      mem_wd = '0;
      if (clr_addr_q == PAIR_W'(PAIRS - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + PAIR_W'(1);
      end
    end

    unique case (state_q)
      fcd_pkg::B_IDLE: begin
        if (!clr_q && !q_empty_i) begin
          q_pop_o = 1'b1;
          pair_d  = rd_addr;
          word_d  = q_head_i.word;
          state_d = fcd_pkg::B_LOAD;
        end
      end
      fcd_pkg::B_LOAD: begin
        mem_we = 1'b1;
        mask_d = rd_data_q ^ word_q;
        if ((rd_data_q ^ word_q) == 16'd0) begin
          state_d = fcd_pkg::B_IDLE;
        end else begin
          state_d = fcd_pkg::B_EMIT;
        end
      end
      fcd_pkg::B_EMIT: begin
        if (out_free) begin
          mask_d      = mask_q & ~(16'd1 << bit_idx);
          out_valid_d = 1'b1;
          out_addr_d  = addr_sum;
          out_occ_d   = word_q[bit_idx];
          out_last_d  = (mask_d == 16'd0);
          if (mask_d == 16'd0) begin
            state_d = fcd_pkg::B_IDLE;
          end
        end
      end
      default: state_d = fcd_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcd_pkg::B_IDLE;
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q     <= pair_d;
    word_q     <= word_d;
    mask_q     <= mask_d;
    out_addr_q <= out_addr_d;
    out_occ_q  <= out_occ_d;
    out_last_q <= out_last_d;
  end

  // level store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lvl_mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= lvl_mem_q[rd_addr];
  end

  assign out_valid_o      = out_valid_q;
  assign sensor_address_o = out_addr_q;
  assign occupied_o       = out_occ_q;
  assign last_o           = out_last_q;

endmodule

### hw/rtl/feedback_change_detector_top.sv
// Occupancy change detector for feedback modules.
// s_axis carries one occupancy report per transfer; m_axis gives one transfer
// per pin that changed, low module first, pins 0..7, tlast on the final one.
// A report whose object number lies below base_object_id, or whose module
// pair falls outside the level store, is consumed with no result; so is a
// report that changes nothing.
// The cfg channel writes base_object_id (reset value 100), always ready; write
// it only while no report is in flight.
// Path to m_axis: queue slot, registered store read (load state), emit state, result register.
// Pace: a report with N changed pins (0..16) passes the back end, which reads the
// store row, writes it back and then shifts out one change per cycle while m_axis
// is ready. A two-entry queue lets the input side run ahead.
// Reset: the level store is cleared by a pass over its MODULES/2 rows, one row
// (two modules) per cycle; s_axis_tready stays low until it ends.
// A stalled m_axis holds its result register and the back end waits; the
// input keeps taking reports until the queue is full.
module feedback_change_detector_top #(
  parameter int unsigned MODULES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // report input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] object_id, [31:16] state_word
  // change output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] sensor_address, [12] occupied, rest zero
  output logic        m_axis_tlast
);

  localparam int unsigned PAIRS = MODULES / 2;

  logic                q_push, q_pop, q_full, q_empty, clearing;
  logic [1:0]          q_count;
  fcd_pkg::fcd_entry_t q_in, q_head;
  logic [11:0]         sensor_address;
  logic                occupied;

  fcd_front #(.PAIRS(PAIRS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .object_id_i  (s_axis_tdata[15:0]),
    .state_word_i (s_axis_tdata[31:16]),
    .q_full_i     (q_full),
    .clearing_i   (clearing),
    .push_o       (q_push),
    .entry_o      (q_in)
  );

  fcd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head),
    .count_o (q_count)
  );

  fcd_back #(.PAIRS(PAIRS)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_head_i         (q_head),
    .q_pop_o          (q_pop),
    .clearing_o       (clearing),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .sensor_address_o (sensor_address),
    .occupied_o       (occupied),
    .last_o           (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, occupied, sensor_address};

  // no report taken while the store is being cleared
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready)
    else $error("report accepted during clearing pass");

  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= 2'(fcd_pkg::QUEUE_DEPTH))
    else $error("queue overflow");

  // nothing reaches the output during the clearing pass
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (!m_axis_tvalid && q_empty))
    else $error("result produced during clearing pass");

endmodule

### test/feedback_change_detector_top_tb.sv
`timescale 1ns / 1ps

module feedback_change_detector_top_tb;

  localparam int unsigned MODULES     = 256;
  localparam int unsigned PAIRS       = MODULES / 2;
  localparam int unsigned ADDR_W      = fcd_pkg::ADDR_W;
  // results may still be on their way, or dropped reports still queued, once
  // nothing is outstanding; the queue is two deep and the back end takes reports in turn
  localparam int          SETTLE      = 40;
  localparam int          CYCLE_LIMIT = 200000;

  // one pin change as seen on m_axis
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              occupied;
    logic              last;
  } pin_change_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] object_id, [31:16] state_word
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [11:0] sensor_address, [12] occupied, rest zero
  logic        m_axis_tlast;

  feedback_change_detector_top #(
    .MODULES(MODULES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the level store and of base_object_id,
  // updated on the transfers the monitor sees.
  // ---------------------------------------------------------------------------
  logic [7:0]  pin_levels [MODULES];
  logic [15:0] base_id;
  pin_change_t change_q [$];    // pin changes still to come out of m_axis

  // stimulus side
  logic [31:0] report_q [$];    // reports waiting for the driver
  logic [15:0] gen_base;        // base the stimulus was written against
  logic [15:0] sent_word [PAIRS]; // last word sent per pair, to shape small deltas
  int          idle_pct;        // chance of starting an idle burst, either side
  int          gap_left;
  int          stall_left;
  logic        report_taken;    // s_axis transfer at the last rising edge

  int          error_count;
  int          cycle_count;
  int          reports_taken;
  int          reports_dropped;
  int          changes_checked;
  int          base_writes;

  // Work out the pin changes one report causes and move the store on.
  // Bit i of the 16-bit view is module 2*pair + i/8, pin i%8, so the sensor
  // address is simply 16*pair + i + 1.
  function automatic void predict_changes(input logic [15:0] obj, input logic [15:0] word);
    int unsigned pair;
    logic [15:0] toggled;
    int          total;
    int          seen;
    logic [ADDR_W-1:0] addr;
    if (obj < base_id) begin
      reports_dropped++;
      return;
    end
    pair = obj - base_id;
    if (2 * pair + 1 >= MODULES) begin
      reports_dropped++;
      return;
    end
    toggled = word ^ {pin_levels[2*pair+1], pin_levels[2*pair]};
    total   = $countones(toggled);
    seen    = 0;
    for (int i = 0; i < 16; i++) begin
      if (toggled[i]) begin
        seen++;
        addr = ADDR_W'(16 * pair + i + 1);
        change_q.push_back('{addr: addr, occupied: word[i], last: (seen == total)});
      end
    end
    pin_levels[2*pair]   = word[7:0];
    pin_levels[2*pair+1] = word[15:8];
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the block's own
  // registers move.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pin_change_t want;
    report_taken = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        base_id = cfg_data_i;
        base_writes++;
      end
      report_taken = s_axis_tvalid && s_axis_tready;
      if (report_taken) begin
        reports_taken++;
        predict_changes(s_axis_tdata[15:0], s_axis_tdata[31:16]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (change_q.size() == 0) begin
          $display("%0t: change transfer with none expected: tdata=%h tlast=%b",
                   $time, m_axis_tdata, m_axis_tlast);
          error_count++;
        end else begin
          want = change_q.pop_front();
          changes_checked++;
          if (m_axis_tdata[11:0] !== want.addr) begin
            $display("%0t: sensor_address expected %0d, got %0d",
                     $time, want.addr, m_axis_tdata[11:0]);
            error_count++;
          end
          if (m_axis_tdata[12] !== want.occupied) begin
            $display("%0t: occupied (address %0d) expected %b, got %b",
                     $time, want.addr, want.occupied, m_axis_tdata[12]);
            error_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: tlast (address %0d) expected %b, got %b",
                     $time, want.addr, want.last, m_axis_tlast);
            error_count++;
          end
          if (m_axis_tdata[15:13] !== 3'b000) begin
            $display("%0t: tdata padding expected 000, got %b",
                     $time, m_axis_tdata[15:13]);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: takes the next report once the current one has transferred,
  // sometimes holding off for a random idle burst first.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || report_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (report_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        gap_left = $urandom_range(1, 4) - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tdata  <= report_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // Receiver back-pressure, same burst pattern as the driver.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(1, 4) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog, far above the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d pin changes still outstanding", $time, change_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_report(input logic [15:0] obj, input logic [15:0] word);
    report_q.push_back({word, obj});
    if (obj >= gen_base && int'(obj) - int'(gen_base) < PAIRS)
      sent_word[obj - gen_base] = word;
  endtask

  // Wait until the block is quiet: nothing queued, nothing owed, and then a
  // settling wait for dropped reports that produce no transfer at all.
  task automatic drain();
    do @(posedge clk_i);
    while (report_q.size() != 0 || s_axis_tvalid || change_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    gen_base = value;
  endtask

  // Next state word for a pair: random words and small deltas on what it holds, so that
  // reports with one or two changes are common, plus full swings and repeats.
  function automatic logic [15:0] pick_word(input logic [15:0] prev);
    logic [15:0] w;
    w = prev;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: w = 16'($urandom);
      4, 5, 6: begin
        repeat ($urandom_range(1, 3)) w[$urandom_range(0, 15)] = ~w[$urandom_range(0, 15)];
      end
      7: w = prev;
      8: w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: w = prev ^ ($urandom_range(0, 1) ? 16'h00FF : 16'hFF00);
    endcase
    return w;
  endfunction

  // n well-formed reports with random content; noise on top does not count
  task automatic random_reports(input int n);
    int sent;
    int top_pair;
    int pair;
    int unsigned obj;
    top_pair = (65535 - int'(gen_base) < PAIRS - 1) ? 65535 - int'(gen_base) : PAIRS - 1;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 15) begin
        // noise: anywhere, just below the base, or just past the store
        case ($urandom_range(0, 2))
          0: obj = $urandom_range(0, 65535);
          1: obj = (gen_base > 0) ? gen_base - 1 : $urandom_range(0, 65535);
          default: obj = int'(gen_base) + PAIRS + $urandom_range(0, 3);
        endcase
        if (obj <= 65535) send_report(16'(obj), 16'($urandom));
      end else begin
        pair = $urandom_range(0, top_pair);
        send_report(16'(int'(gen_base) + pair), pick_word(sent_word[pair]));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    m_axis_tready   = 1'b0;
    report_taken    = 1'b0;
    base_id         = fcd_pkg::BASE_RESET;
    gen_base        = fcd_pkg::BASE_RESET;
    idle_pct        = 25;
    gap_left        = 0;
    stall_left      = 0;
    error_count     = 0;
    cycle_count     = 0;
    reports_taken   = 0;
    reports_dropped = 0;
    changes_checked = 0;
    base_writes     = 0;
    foreach (pin_levels[i]) pin_levels[i] = '0;
    foreach (sent_word[i]) sent_word[i] = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, base 0: the whole store is reachable from object 0 upwards.
    // The report side stalls until the clearing pass after reset is done.
    write_base(16'd0);
    send_report(16'd0,     16'hFFFF);   // every pin of both modules goes occupied
    send_report(16'd0,     16'hFFFF);   // same again: nothing changes
    send_report(16'd0,     16'h0000);   // every pin goes free
    send_report(16'd127,   16'h5AA5);   // top pair of the store, top addresses
    send_report(16'd128,   16'hFFFF);   // pair past the store: dropped
    send_report(16'd65535, 16'hFFFF);   // far past the store: dropped
    send_report(16'd1,     16'h0001);   // lone change, carries tlast
    send_report(16'd1,     16'h8001);   // lone change on the high module's last pin
    send_report(16'd127,   16'hA55A);   // all sixteen pins flip
    send_report(16'd2,     16'h00FF);   // low module only
    send_report(16'd2,     16'hFF00);   // both modules swap
    drain();

    // Base at its top: only object 65535 lands, on pair 0.
    write_base(16'hFFFF);
    send_report(16'd65534, 16'hFFFF);   // below base: dropped
    send_report(16'd65535, 16'h1234);
    send_report(16'd0,     16'hFFFF);   // below base: dropped
    random_reports(15);
    drain();

    // Reset value written back explicitly.
    write_base(16'd100);
    send_report(16'd99,  16'hFFFF);     // just below base: dropped
    send_report(16'd100, 16'hFFFF);
    send_report(16'd227, 16'h0000);     // last pair of the store
    send_report(16'd228, 16'hFFFF);     // first object past the store: dropped
    random_reports(55);
    drain();

    // Store's last pair sits on object 65535; a stretch with no idling.
    idle_pct = 0;
    write_base(16'd65535 - 16'(PAIRS - 1));
    random_reports(45);
    drain();

    idle_pct = 25;
    write_base(16'($urandom_range(0, 65535 - (PAIRS - 1))));
    random_reports(40);
    drain();

    // Closing part at full rate on both sides.
    idle_pct = 0;
    write_base(16'($urandom_range(0, 65535)));
    random_reports(20);
    drain();

    $display("Ran %0d reports (%0d dropped) over %0d base settings, %0d pin changes checked",
             reports_taken, reports_dropped, base_writes, changes_checked);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/fcd_pkg.sv
hw/rtl/fcd_front.sv
hw/rtl/fcd_queue.sv
hw/rtl/fcd_back.sv
hw/rtl/feedback_change_detector_top.sv
test/feedback_change_detector_top_tb.sv
